// File: rtl/core/gh_pkg.sv
// shared types, constants and the gf(2^128) multiply for the ghash accumulator
// no dependencies; used by every module of the block
`default_nettype none

package gh_pkg;

    localparam int DATA_W      = 64;
    localparam int BLOCK_W     = 128;
    localparam int COUNT_W     = 61;
    localparam int BYTE_CNT_W  = 5;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_CNT_W-1:0] BLOCK_BYTES = BYTE_CNT_W'(16);
    localparam logic [COUNT_W-1:0]    COUNT_MAX   = '1;

    // register index taken from paddr[3]
    localparam logic REG_H_HI = 1'b0;
    localparam logic REG_H_LO = 1'b1;

    typedef enum logic [1:0] {
        REQ_RESTART = 2'd0,
        REQ_AAD     = 2'd1,
        REQ_TEXT    = 2'd2,
        REQ_FINAL   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ABSORB = 2'd1,
        OP_FINAL  = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [DATA_W-1:0]     block_hi;
        logic [DATA_W-1:0]     block_lo;
        logic [BYTE_CNT_W-1:0] byte_count;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0] digest_hi;
        logic [DATA_W-1:0] digest_lo;
    } out_t;

    typedef struct packed {
        op_t                op;
        logic [BLOCK_W-1:0] blk;
    } qent_t;

    typedef struct packed {
        logic has_room;
        logic has_data;
    } qstat_t;

    // gcm bit order: msb of the word is the coefficient of x^0
    function automatic logic [BLOCK_W-1:0] gf_mul(input logic [BLOCK_W-1:0] x,
                                                 input logic [BLOCK_W-1:0] y);
        logic [BLOCK_W-1:0]   a;
        logic [BLOCK_W-1:0]   b;
        logic [2*BLOCK_W-2:0] p;
        logic [BLOCK_W-2:0]   q;
        logic [BLOCK_W+5:0]   f;
        logic [5:0]           r;
        logic [BLOCK_W-1:0]   g;
        logic [BLOCK_W-1:0]   z;
        int                   k;
        int                   i;
        for (i = 0; i < BLOCK_W; i++) begin
            a[i] = x[BLOCK_W-1-i];
            b[i] = y[BLOCK_W-1-i];
        end
        // carry-less product, each bit an independent xor tree
        p = '0;
        for (k = 0; k < 2*BLOCK_W-1; k++) begin
            for (i = 0; i < BLOCK_W; i++) begin
                if ((k - i) >= 0 && (k - i) < BLOCK_W) begin
                    p[k] = p[k] ^ (a[i] & b[k-i]);
                end
            end
        end
        // x^128 = 1 + x + x^2 + x^7, folded twice
        q = p[2*BLOCK_W-2:BLOCK_W];
        f = {6'b0, p[BLOCK_W-1:0]} ^ {7'b0, q} ^ {6'b0, q, 1'b0}
            ^ {5'b0, q, 2'b0} ^ {q, 7'b0};
        r = f[BLOCK_W+5:BLOCK_W];
        g = f[BLOCK_W-1:0] ^ {122'b0, r} ^ {121'b0, r, 1'b0}
            ^ {120'b0, r, 2'b0} ^ {115'b0, r, 7'b0};
        for (i = 0; i < BLOCK_W; i++) begin
            z[i] = g[BLOCK_W-1-i];
        end
        return z;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ghash_accumulator_unit.sv
// ghash accumulator: top level with the apb register file for h
// instantiates gh_front, gh_queue and gh_back; uses gh_pkg
//
// usage:
//   write h_hi at address 0 and h_lo at address 8 over apb (64-bit data,
//   pready tied high, reads return the stored half) while the block is idle.
//   request words enter on s_valid/s_ready with s_payload: restart, absorb
//   associated data, absorb text or finalize. only finalize produces a word
//   on m_valid/m_ready, carrying the 128-bit digest in m_payload.
// throughput:
//   one word per cycle sustained while the queue has room. a word is classified
//   and written into the command queue when it is accepted; the back end then
//   applies it with a combinational gf(2^128) multiply, and a finalize loads the
//   digest into the output register that drives m_valid. the multiply inside the
//   accumulator feedback loop sets the one word per cycle figure.
// stalls:
//   while m_ready is low a held digest stalls a finalize at the queue head, and
//   the words behind it wait in the queue; s_ready drops once the queue fills.
// reset:
//   aresetn (synchronous, active low) clears h, the accumulator, both byte
//   counts, the queue and the digest valid flag.
`default_nettype none

module ghash_accumulator_unit #(
    parameter int QUEUE_DEPTH = gh_pkg::QUEUE_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gh_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [gh_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [gh_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire gh_pkg::in_t                    s_payload,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output gh_pkg::out_t                        m_payload
);

    logic [gh_pkg::DATA_W-1:0] h_hi_reg, h_hi_next;
    logic [gh_pkg::DATA_W-1:0] h_lo_reg, h_lo_next;
    logic                      wr_en;
    gh_pkg::qstat_t            q_stat;
    gh_pkg::qent_t             push_ent;
    gh_pkg::qent_t             head_ent;
    logic                      push;
    logic                      pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == gh_pkg::REG_H_LO) ? h_lo_reg : h_hi_reg;

    always_comb begin
        h_hi_next = h_hi_reg;
        h_lo_next = h_lo_reg;
        if (wr_en) begin
            unique case (paddr[3])
                gh_pkg::REG_H_HI: h_hi_next = pwdata;
                gh_pkg::REG_H_LO: h_lo_next = pwdata;
                default:          h_hi_next = h_hi_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_hi_reg <= '0;
            h_lo_reg <= '0;
        end else begin
            h_hi_reg <= h_hi_next;
            h_lo_reg <= h_lo_next;
        end
    end

    gh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_stat    (q_stat),
        .push      (push),
        .push_ent  (push_ent)
    );

    gh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .q_stat   (q_stat),
        .head_ent (head_ent)
    );

    gh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .h         ({h_hi_reg, h_lo_reg}),
        .q_stat    (q_stat),
        .head_ent  (head_ent),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

// File: rtl/core/gh_front.sv
// front end: accepts request words, masks blocks, keeps the byte counts
// and pushes one command per useful word into the queue; uses gh_pkg
`default_nettype none

module gh_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire gh_pkg::in_t   s_payload,
    input  wire gh_pkg::qstat_t q_stat,
    output logic               push,
    output gh_pkg::qent_t      push_ent
);

    logic [gh_pkg::COUNT_W-1:0]    aad_reg, aad_next;
    logic [gh_pkg::COUNT_W-1:0]    text_reg, text_next;
    logic [gh_pkg::BYTE_CNT_W-1:0] nc;
    logic [gh_pkg::BLOCK_W-1:0]    mask;
    logic [gh_pkg::COUNT_W:0]      aad_sum, text_sum;
    logic                          accept;
    gh_pkg::req_t                  req;

    assign s_ready = q_stat.has_room;
    assign accept  = s_valid && s_ready;
    assign req     = gh_pkg::req_t'(s_payload.req_type);
    assign nc      = (s_payload.byte_count > gh_pkg::BLOCK_BYTES) ?
                     gh_pkg::BLOCK_BYTES : s_payload.byte_count;

    always_comb begin
        for (int b = 0; b < 16; b++) begin
            mask[gh_pkg::BLOCK_W-1-8*b -: 8] =
                (gh_pkg::BYTE_CNT_W'(b) < nc) ? 8'hFF : 8'h00;
        end
    end

    assign aad_sum  = {1'b0, aad_reg}  + (gh_pkg::COUNT_W+1)'(nc);
    assign text_sum = {1'b0, text_reg} + (gh_pkg::COUNT_W+1)'(nc);

    always_comb begin
        aad_next     = aad_reg;
        text_next    = text_reg;
        push         = 1'b0;
        push_ent.op  = gh_pkg::OP_CLEAR;
        push_ent.blk = '0;
        if (accept) begin
            unique case (req)
                gh_pkg::REQ_RESTART: begin
                    push      = 1'b1;
                    aad_next  = '0;
                    text_next = '0;
                end
                gh_pkg::REQ_AAD, gh_pkg::REQ_TEXT: begin
                    // a zero byte count absorbs nothing at all
                    if (nc != '0) begin
                        push         = 1'b1;
                        push_ent.op  = gh_pkg::OP_ABSORB;
                        push_ent.blk = {s_payload.block_hi, s_payload.block_lo} & mask;
                        if (req == gh_pkg::REQ_AAD) begin
                            aad_next = aad_sum[gh_pkg::COUNT_W] ?
                                       gh_pkg::COUNT_MAX : aad_sum[gh_pkg::COUNT_W-1:0];
                        end else begin
                            text_next = text_sum[gh_pkg::COUNT_W] ?
                                        gh_pkg::COUNT_MAX : text_sum[gh_pkg::COUNT_W-1:0];
                        end
                    end
                end
                gh_pkg::REQ_FINAL: begin
                    // lengths block in bits
                    push         = 1'b1;
                    push_ent.op  = gh_pkg::OP_FINAL;
                    push_ent.blk = {aad_reg, 3'b000, text_reg, 3'b000};
                    aad_next     = '0;
                    text_next    = '0;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aad_reg  <= '0;
            text_reg <= '0;
        end else begin
            aad_reg  <= aad_next;
            text_reg <= text_next;
        end
    end

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && req == gh_pkg::REQ_RESTART) |=> (aad_reg == '0 && text_reg == '0))
        else $error("restart did not clear the byte counts");

endmodule

`default_nettype wire

// File: rtl/core/gh_queue.sv
// short command queue between front and back ends
// register based, depth from the top level; uses gh_pkg
`default_nettype none

module gh_queue #(
    parameter int DEPTH = gh_pkg::QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire gh_pkg::qent_t  push_ent,
    input  wire logic           pop,
    output gh_pkg::qstat_t      q_stat,
    output gh_pkg::qent_t       head_ent
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gh_pkg::qent_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign q_stat.has_room = (cnt_reg != CNT_W'(DEPTH));
    assign q_stat.has_data = (cnt_reg != '0);
    assign head_ent        = slot_reg[rd_reg];
    assign do_push         = push && q_stat.has_room;
    assign do_pop          = pop && q_stat.has_data;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != '0)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: rtl/core/gh_back.sv
// back end: accumulator, gf(2^128) multiply by h and the digest output register
// uses gh_pkg::gf_mul
`default_nettype none

module gh_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [gh_pkg::BLOCK_W-1:0]  h,
    input  wire gh_pkg::qstat_t              q_stat,
    input  wire gh_pkg::qent_t               head_ent,
    output logic                             pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output gh_pkg::out_t                     m_payload
);

    logic [gh_pkg::BLOCK_W-1:0] acc_reg, acc_next;
    logic [gh_pkg::BLOCK_W-1:0] prod;
    logic                       oval_reg, oval_next;
    gh_pkg::out_t               out_reg, out_next;

    assign prod = gh_pkg::gf_mul(acc_reg ^ head_ent.blk, h);

    // a finalize waits only while an unread digest sits in the output register
    assign pop = q_stat.has_data &&
                 (head_ent.op != gh_pkg::OP_FINAL || !oval_reg || m_ready);

    always_comb begin
        acc_next  = acc_reg;
        oval_next = oval_reg && !m_ready;
        out_next  = out_reg;
        if (pop) begin
            unique case (head_ent.op)
                gh_pkg::OP_ABSORB: begin
                    acc_next = prod;
                end
                gh_pkg::OP_FINAL: begin
                    acc_next  = '0;
                    oval_next = 1'b1;
                    out_next  = prod;
                end
                gh_pkg::OP_CLEAR: begin
                    acc_next = '0;
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            oval_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid   = oval_reg;
    assign m_payload = out_reg;

    a_clear_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_ent.op != gh_pkg::OP_ABSORB) |=> acc_reg == '0)
        else $error("accumulator not cleared after restart or finalize");

endmodule

`default_nettype wire
